// ===== rtl/core/srr_pkg.sv =====
// Shared widths, generator constants and inter-module beat types
// for seeded_random_in_range. No dependencies.
package srr_pkg;

    localparam int SEED_W   = 32;
    localparam int BOUND_W  = 30;
    localparam int RANGE_W  = 31;
    localparam int NUM_W    = 29;
    localparam int DRAW_W   = 15;
    localparam int REM10K_W = 14;
    localparam int VALUE_W  = 32;

    localparam logic [SEED_W-1:0] LCG_MUL = 32'd214013;
    localparam logic [SEED_W-1:0] LCG_ADD = 32'd2531011;
    localparam logic [NUM_W-1:0]  COMBINE_BASE = 29'd10000;

    localparam int SMALL_RANGE_LIMIT_DEF = 32767;
    localparam int DIV_STEPS_DEF         = 4;

    typedef struct packed {
        logic [NUM_W-1:0]          num;
        logic [RANGE_W-1:0]        den;
        logic signed [BOUND_W-1:0] from;
    } t_mod_req;

    typedef struct packed {
        logic [RANGE_W-1:0]        rem;
        logic [NUM_W-1:0]          num;
        logic [RANGE_W-1:0]        den;
        logic signed [BOUND_W-1:0] from;
    } t_div_st;

endpackage

// ===== rtl/core/seeded_random_in_range.sv =====
// Beats pass through the srr_draw front end, the srr_mod remainder
// pipeline and the output register. Throughput: one beat per cycle when not stalled.
// The whole pipeline holds while the output beat is stalled.
// Reset clears all valid bits; no other state.
// Depends on srr_pkg, srr_draw, srr_mod.
module seeded_random_in_range #(
    parameter int SMALL_RANGE_LIMIT = srr_pkg::SMALL_RANGE_LIMIT_DEF,
    parameter int DIV_STEPS         = srr_pkg::DIV_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [srr_pkg::SEED_W-1:0]          i_seed,
    input  logic signed [srr_pkg::BOUND_W-1:0]  i_from_bound,
    input  logic signed [srr_pkg::BOUND_W-1:0]  i_to_bound,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [srr_pkg::VALUE_W-1:0]  o_value
);
    import srr_pkg::*;

    logic                      w_en;
    logic                      w_req_v, w_div_v;
    t_mod_req                  w_req;
    t_div_st                   w_div;
    logic                      r_valid;
    logic signed [VALUE_W-1:0] r_value;

    assign w_en    = !(r_valid && i_stall);
    assign o_stall = !w_en;

    srr_draw #(.SMALL_RANGE_LIMIT(SMALL_RANGE_LIMIT)) u_draw (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid,
        .i_seed, .i_from_bound, .i_to_bound,
        .o_valid(w_req_v), .o_req(w_req)
    );

    srr_mod #(.DIV_STEPS(DIV_STEPS)) u_mod (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_req_v), .i_req(w_req),
        .o_valid(w_div_v), .o_st(w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_value <= VALUE_W'(w_div.from) + VALUE_W'(w_div.rem[BOUND_W-1:0]);
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid set after reset");
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_v |-> (w_div.rem < w_div.den))
        else $error("remainder not below range");
    a_low_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_value >= -(VALUE_W'(1) <<< (BOUND_W-1))))
        else $error("value below lowest bound");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_valid && i_stall) |-> $stable(w_req))
        else $error("pipeline moved while stalled");
endmodule

// ===== rtl/core/srr_draw.sv =====
// Four-stage front end: range, two generator steps, draw combine.
// Depends on srr_pkg.
module srr_draw #(
    parameter int SMALL_RANGE_LIMIT = srr_pkg::SMALL_RANGE_LIMIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [srr_pkg::SEED_W-1:0]        i_seed,
    input  logic signed [srr_pkg::BOUND_W-1:0] i_from_bound,
    input  logic signed [srr_pkg::BOUND_W-1:0] i_to_bound,
    output logic                              o_valid,
    output srr_pkg::t_mod_req                 o_req
);
    import srr_pkg::*;

    logic [3:0]                r_v;
    logic [SEED_W-1:0]         r1_s, r2_s;
    logic [RANGE_W-1:0]        r1_rng, r2_rng, r3_rng;
    logic                      r1_sm, r2_sm, r3_sm;
    logic signed [BOUND_W-1:0] r1_from, r2_from, r3_from;
    logic [DRAW_W-1:0]         r2_d1, r3_d1;
    logic [NUM_W-1:0]          r3_prod;
    logic [REM10K_W-1:0]       r3_rem;
    t_mod_req                  r4_req;

    logic signed [RANGE_W-1:0] n_diff;
    logic [RANGE_W-1:0]        n_rng;
    logic [DRAW_W-1:0]         n_d2;
    logic [REM10K_W-1:0]       n_rem;

    always_comb begin
        n_diff = RANGE_W'(i_to_bound) - RANGE_W'(i_from_bound);
        n_rng  = (n_diff[RANGE_W-1] ? -n_diff : n_diff) + RANGE_W'(1);
        n_d2   = r2_s[30:16];
        if (n_d2 >= 15'd30000) begin
            n_rem = REM10K_W'(n_d2 - 15'd30000);
        end else if (n_d2 >= 15'd20000) begin
            n_rem = REM10K_W'(n_d2 - 15'd20000);
        end else if (n_d2 >= 15'd10000) begin
            n_rem = REM10K_W'(n_d2 - 15'd10000);
        end else begin
            n_rem = REM10K_W'(n_d2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_s    <= i_seed * LCG_MUL + LCG_ADD;
            r1_rng  <= n_rng;
            r1_sm   <= n_rng <= RANGE_W'(SMALL_RANGE_LIMIT);
            r1_from <= i_from_bound;

            r2_s    <= r1_s * LCG_MUL + LCG_ADD;
            r2_d1   <= r1_s[30:16];
            r2_rng  <= r1_rng;
            r2_sm   <= r1_sm;
            r2_from <= r1_from;

            r3_prod <= NUM_W'(r2_d1) * COMBINE_BASE;
            r3_rem  <= n_rem;
            r3_d1   <= r2_d1;
            r3_rng  <= r2_rng;
            r3_sm   <= r2_sm;
            r3_from <= r2_from;

            r4_req.num  <= r3_sm ? NUM_W'(r3_d1) : r3_prod + NUM_W'(r3_rem);
            r4_req.den  <= r3_rng;
            r4_req.from <= r3_from;
        end
    end

    assign o_valid = r_v[3];
    assign o_req   = r4_req;
endmodule

// ===== rtl/core/srr_mod.sv =====
// Pipelined restoring remainder unit, DIV_STEPS dividend bits per stage (fewer in the last).
// Depends on srr_pkg.
module srr_mod #(
    parameter int DIV_STEPS = srr_pkg::DIV_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  srr_pkg::t_mod_req i_req,
    output logic              o_valid,
    output srr_pkg::t_div_st  o_st
);
    import srr_pkg::*;

    localparam int STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;

    t_div_st    r_st [STAGES];
    t_div_st    n_st [STAGES];
    logic [STAGES-1:0] r_v;

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        t_div_st w_in;
        if (k == 0) begin : g_first
            assign w_in = '{rem: '0, num: i_req.num, den: i_req.den, from: i_req.from};
        end else begin : g_next
            assign w_in = r_st[k-1];
        end

        always_comb begin
            n_st[k] = w_in;
            for (int j = 0; j < DIV_STEPS; j++) begin
                if (k * DIV_STEPS + j < NUM_W) begin
                    n_st[k].rem = {n_st[k].rem[RANGE_W-2:0], n_st[k].num[NUM_W-1]};
                    n_st[k].num = {n_st[k].num[NUM_W-2:0], 1'b0};
                    if (n_st[k].rem >= n_st[k].den) begin
                        n_st[k].rem = n_st[k].rem - n_st[k].den;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= STAGES'({r_v, i_valid});
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_st    = r_st[STAGES-1];
endmodule
